>>> rtl/amq_pkg.sv
`timescale 1ns / 1ps

package amq_pkg;

  typedef struct packed {
    logic [31:0] element_bits;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] quant_value;
    logic [31:0]       scale_bits;
    logic              last_out;
    logic              overflow;
  } out_word_t;

  typedef struct packed {
    logic [31:0] elem;
    logic [31:0] scale;
    logic        last;
    logic        ovf;
  } qnt_req_t;

  typedef enum logic [1:0] {
    RND_EVEN = 2'd0,
    RND_ZERO = 2'd1,
    RND_AWAY = 2'd2,
    RND_NONE = 2'd3
  } round_mode_e;

  localparam logic [1:0] CFG_STATIC_MODE = 2'd0;
  localparam logic [1:0] CFG_STATIC_MAX  = 2'd1;
  localparam logic [1:0] CFG_ROUND_MODE  = 2'd2;

  localparam logic [31:0] FP_ONE        = 32'h3F80_0000;
  localparam logic [31:0] FP_MIN_NORMAL = 32'h0080_0000;
  localparam logic [31:0] FP_POS_INF    = 32'h7F80_0000;
  localparam logic [31:0] FP_QUIET_BIT  = 32'h0040_0000;
  localparam logic [23:0] FP_SIG_127    = 24'hFE_0000;

endpackage

>>> rtl/amq_div.sv
`timescale 1ns / 1ps

module amq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] max_i,
  output logic        done_o,
  output logic [31:0] scale_o
);
  import amq_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [25:0] rem_q, rem_d;
  logic [24:0] quo_q, quo_d;
  logic [23:0] div_q, div_d;
  logic [8:0]  exp_q, exp_d;
  logic [31:0] scale_q, scale_d;

  logic        is_nan;
  logic [31:0] m_eff;
  logic [23:0] sig_b;
  logic        a_lt_b;
  logic        ge;
  logic [25:0] diff;
  logic [24:0] quo_f;
  logic        rnd_up;
  logic [24:0] sig_r;
  logic [8:0]  exp_f;

  always_comb begin
    is_nan = (max_i[30:23] == 8'hFF) && (max_i[22:0] != 23'd0);
    m_eff  = (max_i[31] || (max_i[30:0] < FP_MIN_NORMAL[30:0])) ? FP_MIN_NORMAL : max_i;
    sig_b  = {1'b1, m_eff[22:0]};
    a_lt_b = FP_SIG_127 < sig_b;

    ge     = rem_q >= {2'b00, div_q};
    diff   = ge ? rem_q - {2'b00, div_q} : rem_q;
    quo_f  = {quo_q[23:0], ge};
    rnd_up = quo_f[0] & ((diff != 26'd0) | quo_f[1]);
    sig_r  = {1'b0, quo_f[24:1]} + {24'd0, rnd_up};
    exp_f  = exp_q + {8'd0, sig_r[24]};

    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    exp_d   = exp_q;
    scale_d = scale_q;

    if (start_i && !busy_q) begin
      if (is_nan) begin
        scale_d = max_i | FP_QUIET_BIT;
        done_d  = 1'b1;
      end else if (m_eff[30:23] == 8'hFF) begin
        scale_d = 32'd0;
        done_d  = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = 5'd0;
        div_d  = sig_b;
        rem_d  = a_lt_b ? {1'b0, FP_SIG_127, 1'b0} : {2'b00, FP_SIG_127};
        exp_d  = 9'd260 - {1'b0, m_eff[30:23]} - {8'd0, a_lt_b};
        quo_d  = 25'd0;
      end
    end else if (busy_q) begin
      rem_d = {diff[24:0], 1'b0};
      quo_d = quo_f;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd24) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        scale_d = (exp_f >= 9'd255) ? FP_POS_INF
                                    : {1'b0, exp_f[7:0], sig_r[24] ? 23'd0 : sig_r[22:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    div_q   <= div_d;
    exp_q   <= exp_d;
    scale_q <= scale_d;
  end

  assign done_o  = done_q;
  assign scale_o = scale_q;

endmodule

>>> rtl/amq_quant.sv
`timescale 1ns / 1ps

module amq_quant (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  amq_pkg::qnt_req_t req_i,
  input  logic [1:0]        round_mode_i,
  output logic              out_valid_o,
  output amq_pkg::out_word_t out_word_o
);
  import amq_pkg::*;

  function automatic logic [4:0] lead_zeros(input logic [22:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // normalize stage
  logic               v1_q;
  logic               sgn1_q;
  logic signed [10:0] ex1_q, es1_q;
  logic [23:0]        mx1_q, ms1_q;
  logic               xnan1_q, xinf1_q, xzero1_q;
  logic               snan1_q, sinf1_q, szero1_q;
  logic [31:0]        sc1_q;
  logic               last1_q, ovf1_q;

  // multiply stage
  logic               v2_q;
  logic               sgn2_q;
  logic signed [10:0] esum2_q;
  logic [47:0]        p2_q;
  logic               nan2_q, inf2_q, zero2_q;
  logic [31:0]        sc2_q;
  logic               last2_q, ovf2_q;

  logic               out_valid_q;
  out_word_t          out_word_q;

  logic [7:0]         xe;
  logic [22:0]        xf;
  logic [4:0]         lz;
  logic signed [10:0] ex_d;
  logic [23:0]        mx_d;

  always_comb begin
    xe = req_i.elem[30:23];
    xf = req_i.elem[22:0];
    lz = lead_zeros(xf);
    if (xe == 8'd0) begin
      mx_d = {xf, 1'b0} << lz;
      ex_d = -11'sd127 - signed'({6'd0, lz});
    end else begin
      mx_d = {1'b1, xf};
      ex_d = signed'({3'd0, xe}) - 11'sd127;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn1_q   <= req_i.elem[31] ^ req_i.scale[31];
      ex1_q    <= ex_d;
      mx1_q    <= mx_d;
      xnan1_q  <= (xe == 8'hFF) && (xf != 23'd0);
      xinf1_q  <= (xe == 8'hFF) && (xf == 23'd0);
      xzero1_q <= req_i.elem[30:0] == 31'd0;
      es1_q    <= signed'({3'd0, req_i.scale[30:23]}) - 11'sd127;
      ms1_q    <= {1'b1, req_i.scale[22:0]};
      snan1_q  <= (req_i.scale[30:23] == 8'hFF) && (req_i.scale[22:0] != 23'd0);
      sinf1_q  <= (req_i.scale[30:23] == 8'hFF) && (req_i.scale[22:0] == 23'd0);
      szero1_q <= req_i.scale[30:23] == 8'd0;
      sc1_q    <= req_i.scale;
      last1_q  <= req_i.last;
      ovf1_q   <= req_i.ovf;

      sgn2_q  <= sgn1_q;
      esum2_q <= ex1_q + es1_q;
      p2_q    <= mx1_q * ms1_q;
      nan2_q  <= xnan1_q | snan1_q | (xinf1_q & szero1_q) | (xzero1_q & sinf1_q);
      inf2_q  <= xinf1_q | sinf1_q;
      zero2_q <= xzero1_q | szero1_q;
      sc2_q   <= sc1_q;
      last2_q <= last1_q;
      ovf2_q  <= ovf1_q;
    end
  end

  // round product to single, then to integer
  logic               hi;
  logic [23:0]        mant_pre;
  logic               g, s, up;
  logic [24:0]        sig_r;
  logic signed [10:0] e_v;
  logic [23:0]        mant;
  logic [30:0]        w;
  logic [6:0]         ip;
  logic               up2;
  logic [7:0]         mag;
  logic [7:0]         q_d;
  logic [2:0]         sh;

  always_comb begin
    hi       = p2_q[47];
    mant_pre = hi ? p2_q[47:24] : p2_q[46:23];
    g        = hi ? p2_q[23] : p2_q[22];
    s        = hi ? (p2_q[22:0] != 23'd0) : (p2_q[21:0] != 22'd0);
    up       = g & (s | mant_pre[0]);
    sig_r    = {1'b0, mant_pre} + {24'd0, up};
    e_v      = esum2_q + signed'({10'd0, hi}) + signed'({10'd0, sig_r[24]});
    mant     = sig_r[24] ? 24'h80_0000 : sig_r[23:0];
    sh       = 3'(e_v + 11'sd1);
    w        = {7'd0, mant} << sh;
    ip       = w[30:24];
    unique case (round_mode_e'(round_mode_i))
      RND_EVEN: up2 = w[23] & ((w[22:0] != 23'd0) | ip[0]);
      RND_ZERO: up2 = 1'b0;
      RND_AWAY: up2 = w[23];
      default:  up2 = 1'b0;
    endcase
    mag = {1'b0, ip} + {7'd0, up2};

    priority if (round_mode_e'(round_mode_i) == RND_NONE || nan2_q) begin
      q_d = 8'd0;
    end else if (inf2_q || (!zero2_q && e_v >= 11'sd7)) begin
      q_d = sgn2_q ? 8'h80 : 8'h7F;
    end else if (zero2_q || e_v < -11'sd1) begin
      q_d = 8'd0;
    end else if (sgn2_q) begin
      q_d = 8'd0 - mag;
    end else begin
      q_d = (mag > 8'd127) ? 8'h7F : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_word_q.quant_value <= signed'(q_d);
      out_word_q.scale_bits  <= sc2_q;
      out_word_q.last_out    <= last2_q;
      out_word_q.overflow    <= ovf2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/int8_abs_max_quantizer_top.sv
// Symmetric int8 quantizer for a stream of single-precision words. In dynamic
// mode each word is written into a buffer while the largest magnitude is
// tracked; the word marked last starts the scale computation
// (127 / max on a one-bit-per-cycle divider), after which the buffered words
// leave one per cycle, while the output is not stalled, through a three-stage
// multiply and round pipeline. In static mode every word runs the same
// divider and pipeline; a new word is taken once the last one is read into
// the pipeline. Words beyond MAX_ELEMENTS are dropped and flagged in overflow.
`timescale 1ns / 1ps

module int8_abs_max_quantizer_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  amq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output amq_pkg::out_word_t out_word_o
);
  import amq_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic        static_mode_q;
  logic [31:0] static_max_q;
  logic [1:0]  round_mode_q;

  logic [CW-1:0] count_q, count_d;
  logic [30:0]   max_q, max_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] n_q, n_d;
  logic          lastflag_q, lastflag_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic          stat_sel_q, stat_sel_d;

  logic [31:0] mem [MAX_ELEMENTS];
  logic [31:0] stat_elem_q;
  logic [31:0] rdata_q;
  logic        v0_q;
  logic [31:0] sc0_q;
  logic        last0_q, ovf0_q;

  logic          acc, room, en, rd_en, is_last_rd;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [30:0]   mag;
  logic          div_start, div_done;
  logic [31:0]   div_max, div_scale;
  qnt_req_t      req;

  assign acc        = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign en         = !out_valid_o || !out_stall_i;
  assign room       = count_q < CW'(MAX_ELEMENTS);
  assign mag        = in_word_i.element_bits[30:0];
  assign rd_en      = (state_q == ST_EMIT) && en;
  assign is_last_rd = (rd_cnt_q + CW'(1)) == n_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    max_d      = max_q;
    drop_d     = drop_q;
    n_d        = n_q;
    lastflag_d = lastflag_q;
    ovf_d      = ovf_q;
    rd_cnt_d   = rd_cnt_q;
    stat_sel_d = stat_sel_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    div_start  = 1'b0;
    div_max    = static_max_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc && static_mode_q) begin
          stat_sel_d = 1'b1;
          n_d        = CW'(1);
          lastflag_d = in_word_i.last_in;
          ovf_d      = 1'b0;
          div_start  = 1'b1;
          state_d    = ST_DIV;
        end else if (acc) begin
          if (room) begin
            wr_en   = 1'b1;
            wr_addr = count_q[AW-1:0];
            count_d = count_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (mag <= FP_POS_INF[30:0] && mag > max_q) max_d = mag;
          if (in_word_i.last_in) begin
            stat_sel_d = 1'b0;
            n_d        = count_d;
            lastflag_d = 1'b1;
            ovf_d      = drop_d;
            div_max    = {1'b0, max_d};
            div_start  = 1'b1;
            count_d    = '0;
            max_d      = '0;
            drop_d     = 1'b0;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          rd_cnt_d = '0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + CW'(1);
          if (is_last_rd) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      static_mode_q <= 1'b0;
      static_max_q  <= FP_ONE;
      round_mode_q  <= RND_EVEN;
      count_q       <= '0;
      max_q         <= '0;
      drop_q        <= 1'b0;
      n_q           <= '0;
      lastflag_q    <= 1'b0;
      ovf_q         <= 1'b0;
      rd_cnt_q      <= '0;
      stat_sel_q    <= 1'b0;
      v0_q          <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      max_q      <= max_d;
      drop_q     <= drop_d;
      n_q        <= n_d;
      lastflag_q <= lastflag_d;
      ovf_q      <= ovf_d;
      rd_cnt_q   <= rd_cnt_d;
      stat_sel_q <= stat_sel_d;
      if (en) v0_q <= rd_en;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STATIC_MODE: static_mode_q <= cfg_data_i[0];
          CFG_STATIC_MAX:  static_max_q  <= cfg_data_i;
          CFG_ROUND_MODE:  round_mode_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= in_word_i.element_bits;
    if (acc && static_mode_q) stat_elem_q <= in_word_i.element_bits;
    if (rd_en) begin
      rdata_q <= stat_sel_q ? stat_elem_q : mem[rd_cnt_q[AW-1:0]];
      sc0_q   <= div_scale;
      last0_q <= lastflag_q && is_last_rd;
      ovf0_q  <= ovf_q;
    end
  end

  amq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .max_i   (div_max),
    .done_o  (div_done),
    .scale_o (div_scale)
  );

  always_comb begin
    req.elem  = rdata_q;
    req.scale = sc0_q;
    req.last  = last0_q;
    req.ovf   = ovf0_q;
  end

  amq_quant u_quant (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (v0_q),
    .req_i        (req),
    .round_mode_i (round_mode_q),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o)
  );

endmodule
